[hw/rtl/fhm_pkg.sv]
package fhm_pkg;

    // Fixed field widths of the request and result ports
    localparam int ID_W        = 4;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 5;

    // Default wait queue depth
    localparam int QUEUE_DEPTH_DEF = 16;

    // Operation codes carried on func
    localparam logic FUNC_LOCK   = 1'b0;
    localparam logic FUNC_UNLOCK = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_RELEASED  = 3'd2,
        ST_HANDOFF   = 3'd3,
        ST_FULL      = 3'd4,
        ST_NOT_OWNER = 3'd5,
        ST_ALREADY   = 3'd6
    } fhm_status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch;   // capture the incoming request
        logic commit;  // execute the captured request and load the result
    } fhm_cmd_t;

endpackage

[hw/rtl/fhm_ctrl.sv]
module fhm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output fhm_pkg::fhm_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd.latch  = (state_reg == S_IDLE) && in_valid;
        cmd.commit = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("result not presented after commit");

    a_no_commit_over_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !cmd.commit)
        else $error("commit over a stalled result");

    a_valid_rise_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.commit))
        else $error("result valid without a commit");

endmodule

[hw/rtl/fhm_dp.sv]
module fhm_dp
#(
    parameter int QUEUE_DEPTH = fhm_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  fhm_pkg::fhm_cmd_t                cmd,
    input  logic                             func,
    input  logic [fhm_pkg::ID_W-1:0]         requester,
    output logic [fhm_pkg::STATUS_W-1:0]     status,
    output logic [fhm_pkg::ID_W-1:0]         owner,
    output logic                             held,
    output logic                             waiters_flag,
    output logic [fhm_pkg::COUNT_OUT_W-1:0]  waiter_count
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [fhm_pkg::ID_W-1:0] wait_mem [QUEUE_DEPTH];

    logic                     func_reg;
    logic [fhm_pkg::ID_W-1:0] req_reg;
    logic [fhm_pkg::ID_W-1:0] head_data_reg;

    logic [fhm_pkg::ID_W-1:0] owner_reg;
    logic [fhm_pkg::ID_W-1:0] owner_next;
    logic                     held_reg;
    logic                     held_next;
    logic [PTR_W-1:0]         head_reg;
    logic [PTR_W-1:0]         head_next;
    logic [PTR_W-1:0]         tail_reg;
    logic [PTR_W-1:0]         tail_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    fhm_pkg::fhm_status_t     status_reg;
    fhm_pkg::fhm_status_t     status_next;
    logic                     push;

    always_comb
    begin
        owner_next  = owner_reg;
        held_next   = held_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = fhm_pkg::ST_NOT_OWNER;
        push        = 1'b0;
        if (func_reg == fhm_pkg::FUNC_LOCK)
        begin
            if (!held_reg)
            begin
                owner_next  = req_reg;
                held_next   = 1'b1;
                status_next = fhm_pkg::ST_GRANTED;
            end
            else if (owner_reg == req_reg)
            begin
                status_next = fhm_pkg::ST_ALREADY;
            end
            else if (count_reg >= CNT_FULL)
            begin
                status_next = fhm_pkg::ST_FULL;
            end
            else
            begin
                push        = 1'b1;
                tail_next   = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                count_next  = count_reg + 1'b1;
                status_next = fhm_pkg::ST_QUEUED;
            end
        end
        else
        begin
            if (!held_reg || owner_reg != req_reg)
            begin
                status_next = fhm_pkg::ST_NOT_OWNER;
            end
            else if (count_reg == '0)
            begin
                owner_next  = '0;
                held_next   = 1'b0;
                status_next = fhm_pkg::ST_RELEASED;
            end
            else
            begin
                // hand ownership straight to the queue head
                owner_next  = head_data_reg;
                head_next   = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                count_next  = count_reg - 1'b1;
                status_next = fhm_pkg::ST_HANDOFF;
            end
        end
    end

    // Prefetch the head entry; it is settled by the time a captured request commits
    always_ff @(posedge clk)
    begin
        head_data_reg <= wait_mem[head_reg];
        if (cmd.commit && push)
        begin
            wait_mem[tail_reg] <= req_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg <= func;
            req_reg  <= requester;
        end
        if (cmd.commit)
        begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owner_reg <= '0;
            held_reg  <= 1'b0;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            owner_reg <= owner_next;
            held_reg  <= held_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign status       = status_reg;
    assign owner        = owner_reg;
    assign held         = held_reg;
    assign waiters_flag = (count_reg != '0);
    assign waiter_count = fhm_pkg::COUNT_OUT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("wait queue count beyond depth");

    a_free_owner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !held_reg |-> (owner_reg == '0 && count_reg == '0))
        else $error("free lock with owner or waiters");

    a_handoff_keeps_held: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && status_next == fhm_pkg::ST_HANDOFF) |=>
            (held_reg && count_reg == $past(count_reg) - 1'b1))
        else $error("handoff did not keep the lock held");

endmodule

[hw/rtl/fifo_handoff_mutex_core.sv]
// Lock unit with FIFO wait queue and direct handoff to the oldest waiter.
// A new request is taken only in the idle state, after the last has committed;
// the idle state lets the single read port of the wait queue prefetch the head
// entry after each update. Commit waits while a previous result is stalled.
// Reset (rst_n, asynchronous, active low) frees the lock and empties the queue;
// queue storage itself is not cleared, since only written entries are used.
module fifo_handoff_mutex_core
#(
    parameter int QUEUE_DEPTH = fhm_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             func,
    input  logic [fhm_pkg::ID_W-1:0]         requester,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fhm_pkg::STATUS_W-1:0]     status,
    output logic [fhm_pkg::ID_W-1:0]         owner,
    output logic                             held,
    output logic                             waiters_flag,
    output logic [fhm_pkg::COUNT_OUT_W-1:0]  waiter_count
);

    // Commands: latch captures a request, commit executes it atomically and
    // loads the result register. Commit waits while a previous result is
    // still stalled, so owner and queue state always match the shown result.
    fhm_pkg::fhm_cmd_t cmd;

    // Controller: request acceptance, commit timing, result valid
    fhm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Datapath: owner register, queue pointers and count, wait queue storage
    fhm_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .requester    (requester),
        .status       (status),
        .owner        (owner),
        .held         (held),
        .waiters_flag (waiters_flag),
        .waiter_count (waiter_count)
    );

endmodule

[test/lock_tracker_pkg.sv]
`timescale 1ns / 100ps
package lock_tracker_pkg;
    import fhm_pkg::*;

    typedef struct {
        fhm_status_t             status;
        logic [ID_W-1:0]         owner;
        logic                    held;
        logic                    waiters_flag;
        logic [COUNT_OUT_W-1:0]  waiter_count;
    } lock_outcome_t;

    // Shadow of the lock unit: owner, wait queue and the outcomes still owed.
    class lock_tracker;
        logic [ID_W-1:0] owner_id = '0;
        logic            lock_held = 1'b0;
        logic [ID_W-1:0] waiter_fifo [QUEUE_DEPTH_DEF];
        int unsigned     head_ptr = 0;
        int unsigned     tail_ptr = 0;
        int unsigned     waiting = 0;
        int unsigned     mismatches = 0;
        lock_outcome_t   pending_outcomes [$];

        function int unsigned outstanding();
            return pending_outcomes.size();
        endfunction

        // Apply one accepted request and queue the outcome it must produce
        function void record_request(logic op, logic [ID_W-1:0] who);
            lock_outcome_t o;
            if (op == FUNC_LOCK)
            begin
                if (!lock_held)
                begin
                    owner_id  = who;
                    lock_held = 1'b1;
                    o.status  = ST_GRANTED;
                end
                else if (owner_id == who)
                    o.status = ST_ALREADY;
                else if (waiting >= QUEUE_DEPTH_DEF)
                    o.status = ST_FULL;
                else
                begin
                    waiter_fifo[tail_ptr] = who;
                    tail_ptr = (tail_ptr + 1 >= QUEUE_DEPTH_DEF) ? 0 : tail_ptr + 1;
                    waiting++;
                    o.status = ST_QUEUED;
                end
            end
            else
            begin
                if (!lock_held || owner_id != who)
                    o.status = ST_NOT_OWNER;
                else if (waiting == 0)
                begin
                    owner_id  = '0;
                    lock_held = 1'b0;
                    o.status  = ST_RELEASED;
                end
                else
                begin
                    owner_id = waiter_fifo[head_ptr];
                    head_ptr = (head_ptr + 1 >= QUEUE_DEPTH_DEF) ? 0 : head_ptr + 1;
                    waiting--;
                    o.status = ST_HANDOFF;
                end
            end
            o.owner        = owner_id;
            o.held         = lock_held;
            o.waiters_flag = (waiting != 0);
            o.waiter_count = COUNT_OUT_W'(waiting);
            pending_outcomes.push_back(o);
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task compare_outcome(input logic [STATUS_W-1:0] st, input logic [ID_W-1:0] own,
                             input logic hld, input logic wflag,
                             input logic [COUNT_OUT_W-1:0] wcount);
            lock_outcome_t want;
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("result with no request outstanding");
                return;
            end
            want = pending_outcomes.pop_front();
            if (st !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", st, want.status));
            if (own !== want.owner)
                report_mismatch($sformatf("owner %0d, want %0d", own, want.owner));
            if (hld !== want.held)
                report_mismatch($sformatf("held %0b, want %0b", hld, want.held));
            if (wflag !== want.waiters_flag)
                report_mismatch($sformatf("waiters_flag %0b, want %0b",
                                          wflag, want.waiters_flag));
            if (wcount !== want.waiter_count)
                report_mismatch($sformatf("waiter_count %0d, want %0d",
                                          wcount, want.waiter_count));
        endtask
    endclass

endpackage

[test/testbench.sv]
`timescale 1ns / 100ps
module testbench;
    import fhm_pkg::*;
    import lock_tracker_pkg::*;

    // Generous ceiling: far above the worst case for ~1950 requests
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_PHASES = 6;
    localparam int unsigned PHASE_ITEMS   = 320;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    func;
    logic [ID_W-1:0]         requester;
    logic                    out_valid;
    logic                    out_stall;
    logic [STATUS_W-1:0]     status;
    logic [ID_W-1:0]         owner;
    logic                    held;
    logic                    waiters_flag;
    logic [COUNT_OUT_W-1:0]  waiter_count;

    // Largest idle gap each side may draw per item; zero gives a stretch with no idling
    int unsigned in_gap_max  = 9;
    int unsigned out_gap_max = 9;
    int unsigned stall_left  = 0;
    int unsigned cycle_count = 0;

    lock_tracker tracker = new;

    fifo_handoff_mutex_core i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .requester    (requester),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .owner        (owner),
        .held         (held),
        .waiters_flag (waiters_flag),
        .waiter_count (waiter_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Present one request after a random gap, hold it until accepted, then
    // update the shadow lock so the next choice sees the new owner.
    task automatic send_request(input logic op, input logic [ID_W-1:0] who);
        int unsigned gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= op;
        requester <= who;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.record_request(op, who);
    endtask

    // Stall the result channel for a freshly drawn number of cycles after each
    // accepted result, so stalls land on every phase of the unit's work.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                stall_left = $urandom_range(0, out_gap_max);
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Check every accepted result against the oldest outstanding prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.compare_outcome(status, owner, held, waiters_flag, waiter_count);
    end

    // Watchdog: drop the run if the unit stops answering
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("fifo_handoff_mutex_core verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned   phase;
        int unsigned   n;
        int unsigned   roll;
        int unsigned   lock_pct;
        int unsigned   lock_pct_tab [RANDOM_PHASES];

        lock_pct_tab = '{50, 85, 25, 70, 40, 60};

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        func      <= FUNC_LOCK;
        requester <= '0;
        out_stall <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unlock on a free lock, grant, relock by owner, unlock by
        // a stranger, repeated waiter, handoff chain, release to free, stray unlock, regrant.
        send_request(FUNC_UNLOCK, 4'd0);
        send_request(FUNC_LOCK,   4'd0);
        send_request(FUNC_LOCK,   4'd0);
        send_request(FUNC_UNLOCK, 4'd15);
        send_request(FUNC_LOCK,   4'd15);
        send_request(FUNC_LOCK,   4'd15);
        send_request(FUNC_UNLOCK, 4'd0);
        send_request(FUNC_UNLOCK, 4'd15);
        send_request(FUNC_UNLOCK, 4'd15);
        send_request(FUNC_UNLOCK, 4'd15);
        send_request(FUNC_LOCK,   4'd15);

        // Fill the wait queue to the brim, then push against it: a stranger
        // hits queue full, the owner still gets already-owner, and a stranger cannot unlock.
        for (n = 0; n < QUEUE_DEPTH_DEF; n++)
            send_request(FUNC_LOCK, ID_W'(n % 15));
        send_request(FUNC_LOCK,   4'd3);
        send_request(FUNC_LOCK,   4'd15);
        send_request(FUNC_UNLOCK, 4'd7);

        // Random: mostly well-formed traffic (locks from anyone, unlocks by the
        // real owner) with stray unlocks as noise. Lock bias varies per phase so
        // the queue swings between empty and full.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            lock_pct    = lock_pct_tab[phase];
            in_gap_max  = (phase == 2 || phase == 4) ? 0 : 9;
            out_gap_max = (phase == 3 || phase == 4) ? 0 : 9;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < lock_pct)
                    send_request(FUNC_LOCK, ID_W'($urandom_range(0, 15)));
                else if (roll < 90 && tracker.lock_held)
                    send_request(FUNC_UNLOCK, tracker.owner_id);
                else
                    send_request(FUNC_UNLOCK, ID_W'($urandom_range(0, 15)));
            end
        end

        in_valid <= 1'b0;

        // Drain: wait for every owed result, then let any stray result show up
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("fifo_handoff_mutex_core verification clean");
        else
            $display("fifo_handoff_mutex_core verification failed");
        $finish;
    end

endmodule
